// File: src/lpht_pkg.sv
// Package for the linear probe hash table unit: command, status and state codes,
// field widths and the key byte helpers. No dependencies.
package lpht_pkg;

    localparam int TABLE_DEPTH_DEF   = 64;
    localparam int KEY_BYTES_DEF     = 8;
    localparam int PAYLOAD_BYTES_DEF = 8;

    localparam int WORD_W  = 64;
    localparam int LEN_W   = 4;
    localparam int CAP_W   = 7;
    localparam int SLOT_W  = 6;
    localparam int COUNT_W = 7;
    localparam int SUM_W   = 11;
    localparam int CFG_W   = 7;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DELETE = 2'd1,
        CMD_GET    = 2'd2,
        CMD_UPDATE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK           = 3'd0,
        ST_FULL         = 3'd1,
        ST_KEY_LONG     = 3'd2,
        ST_PAYLOAD_LONG = 3'd3,
        ST_EXISTS       = 3'd4,
        ST_NOT_FOUND    = 3'd5
    } status_t;

    typedef enum logic [1:0] {
        CFG_CAPACITY    = 2'd0,
        CFG_MAX_KEY     = 2'd1,
        CFG_MAX_PAYLOAD = 2'd2
    } cfg_idx_t;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_HASH,
        S_PROBE,
        S_RESULT
    } state_t;

    function automatic logic [WORD_W-1:0] byte_mask(input logic [LEN_W-1:0] len);
        logic [WORD_W-1:0] m;
        m = '0;
        for (int i = 0; i < WORD_W / 8; i++)
        begin
            if (LEN_W'(i) < len)
                m[8*i +: 8] = 8'hFF;
        end
        return m;
    endfunction

    function automatic logic [SUM_W-1:0] key_sum(input logic [WORD_W-1:0] key);
        logic [SUM_W-1:0] s;
        s = '0;
        for (int i = 0; i < WORD_W / 8; i++)
            s = s + SUM_W'(key[8*i +: 8]);
        return s;
    endfunction

endpackage

// File: src/lpht_if.sv
// Channel interfaces of the linear probe hash table unit: command and result.
// Depends on lpht_pkg.
interface lpht_cmd_if import lpht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [1:0]          cmd;
    logic [WORD_W-1:0]   key_word;
    logic [LEN_W-1:0]    key_length;
    logic [WORD_W-1:0]   payload_word;
    logic [LEN_W-1:0]    payload_length;

    modport source (output valid, cmd, key_word, key_length, payload_word, payload_length,
                    input ready);
    modport sink   (input valid, cmd, key_word, key_length, payload_word, payload_length,
                    output ready);
endinterface

interface lpht_res_if import lpht_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [2:0]          status;
    logic [WORD_W-1:0]   found_payload;
    logic [LEN_W-1:0]    found_payload_length;
    logic [SLOT_W-1:0]   slot_index;
    logic [COUNT_W-1:0]  entry_count;

    modport source (output valid, status, found_payload, found_payload_length, slot_index,
                    entry_count, input ready);
    modport sink   (input valid, status, found_payload, found_payload_length, slot_index,
                    entry_count, output ready);
endinterface

// File: src/lpht_mod.sv
// Bit-serial remainder unit: key byte sum modulo the table capacity, one bit a cycle.
// Depends on lpht_pkg.
module lpht_mod import lpht_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [CAP_W-1:0] divisor,
    output logic             done,
    output logic [CAP_W-1:0] rem
);
    localparam int CW = $clog2(SUM_W);

    logic             busy_reg, busy_next;
    logic             done_reg, done_next;
    logic [CW-1:0]    cnt_reg, cnt_next;
    logic [SUM_W-1:0] num_reg, num_next;
    logic [CAP_W-1:0] rem_reg, rem_next;
    logic [CAP_W-1:0] div_reg, div_next;
    logic [CAP_W:0]   trial;

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        rem_next  = rem_reg;
        div_next  = div_reg;
        trial     = {rem_reg, num_reg[SUM_W-1]};
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = '0;
            num_next  = dividend;
            rem_next  = '0;
            div_next  = divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, div_reg})
                rem_next = CAP_W'(trial - {1'b0, div_reg});
            else
                rem_next = trial[CAP_W-1:0];
            num_next = {num_reg[SUM_W-2:0], 1'b0};
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == CW'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg <= num_next;
        rem_reg <= rem_next;
        div_reg <= div_next;
    end

    assign done = done_reg;
    assign rem  = rem_reg;

endmodule

// File: src/linear_probe_hash_table_unit.sv
// Linear probe hash table unit: key-value table with open addressing in one memory.
// Depends on lpht_pkg, lpht_if (lpht_cmd_if, lpht_res_if) and lpht_mod.
//
// Commands (insert, delete, get, update) arrive as beats on cmd_ch; each gives
// exactly one result beat on res_ch. One command is in flight at a time: cmd_ch
// is ready only when the unit is idle and the previous result has been taken.
// A command refused by its length or fill checks answers in the cycle after
// acceptance. Others run the serial remainder of the key byte sum, then one
// memory read per probe slot, pipelined through the registered memory read,
// and a drain of the last read before the answer. The probe count sets the rate.
// The user must write configuration (cfg_we, cfg_index, cfg_data) only while
// the unit is idle; the unit itself does not enforce this.
// After reset a clearing pass writes every one of the TABLE_DEPTH entries empty,
// one a cycle, while cmd_ch is not ready. A stalled result holds on res_ch until
// taken; no new command is accepted meanwhile.
module linear_probe_hash_table_unit import lpht_pkg::*;
#(
    parameter int TABLE_DEPTH   = TABLE_DEPTH_DEF,
    parameter int KEY_BYTES     = KEY_BYTES_DEF,
    parameter int PAYLOAD_BYTES = PAYLOAD_BYTES_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    lpht_cmd_if.sink         cmd_ch,
    lpht_res_if.source       res_ch,
    input  logic             cfg_we,
    input  logic [1:0]       cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);
    localparam int IDX_W   = $clog2(TABLE_DEPTH);
    localparam int CNT_W   = $clog2(TABLE_DEPTH + 1);
    localparam int CMP_W   = (CNT_W > CAP_W) ? CNT_W : CAP_W;
    localparam int CAP_LIM = (TABLE_DEPTH < 127) ? TABLE_DEPTH : 127;
    localparam int KW      = 8 * KEY_BYTES;
    localparam int PW      = 8 * PAYLOAD_BYTES;

    typedef struct packed {
        logic             valid;
        logic [KW-1:0]    key;
        logic [LEN_W-1:0] klen;
        logic [PW-1:0]    pay;
        logic [LEN_W-1:0] plen;
    } entry_t;

    entry_t mem [TABLE_DEPTH];
    entry_t rd_data_reg;
    entry_t mem_wdata;
    logic   mem_we;
    logic [IDX_W-1:0] mem_waddr, mem_raddr;

    state_t state_reg, state_next;

    logic [CAP_W-1:0] cap_cfg_reg;
    logic [LEN_W-1:0] max_klen_reg, max_plen_reg;
    logic [CAP_W-1:0] cap_eff;

    cmd_t             op_reg, op_next;
    logic [WORD_W-1:0] key_reg, key_next;
    logic [LEN_W-1:0] klen_reg, klen_next;
    logic [PW-1:0]    pay_reg, pay_next;
    logic [LEN_W-1:0] plen_reg, plen_next;

    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic [IDX_W-1:0] clr_reg, clr_next;
    logic [CAP_W-1:0] probe_reg, probe_next;
    logic [CAP_W-1:0] issued_reg, issued_next;
    logic             chk_vld_reg, chk_vld_next;
    logic [CAP_W-1:0] chk_slot_reg, chk_slot_next;

    status_t          status_reg, status_next;
    logic [WORD_W-1:0] fpay_reg, fpay_next;
    logic [LEN_W-1:0] fplen_reg, fplen_next;
    logic [SLOT_W-1:0] slot_reg, slot_next;

    logic             accept, key_long, pay_long, full, early, issue, match;
    logic [WORD_W-1:0] key_m, pay_m;
    logic             mod_start, mod_done;
    logic [CAP_W-1:0] mod_rem;

    always_comb
    begin
        if (cap_cfg_reg == '0)
            cap_eff = CAP_W'(1);
        else if (int'(cap_cfg_reg) > CAP_LIM)
            cap_eff = CAP_W'(CAP_LIM);
        else
            cap_eff = cap_cfg_reg;
    end

    assign accept   = cmd_ch.valid && cmd_ch.ready;
    assign key_m    = cmd_ch.key_word & byte_mask(cmd_ch.key_length);
    assign pay_m    = cmd_ch.payload_word & byte_mask(cmd_ch.payload_length);
    assign key_long = (cmd_ch.key_length > max_klen_reg) ||
                      (cmd_ch.key_length > LEN_W'(KEY_BYTES));
    assign pay_long = (cmd_ch.payload_length > max_plen_reg) ||
                      (cmd_ch.payload_length > LEN_W'(PAYLOAD_BYTES));
    assign full     = CMP_W'(cnt_reg) >= CMP_W'(cap_eff);
    assign issue    = issued_reg != cap_eff;
    assign match    = rd_data_reg.valid && (rd_data_reg.klen == klen_reg) &&
                      (rd_data_reg.key == key_reg[KW-1:0]);

    lpht_mod u_mod (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (mod_start),
        .dividend (key_sum(key_m)),
        .divisor  (cap_eff),
        .done     (mod_done),
        .rem      (mod_rem)
    );

    always_comb
    begin
        state_next    = state_reg;
        op_next       = op_reg;
        key_next      = key_reg;
        klen_next     = klen_reg;
        pay_next      = pay_reg;
        plen_next     = plen_reg;
        cnt_next      = cnt_reg;
        clr_next      = clr_reg;
        probe_next    = probe_reg;
        issued_next   = issued_reg;
        chk_vld_next  = 1'b0;
        chk_slot_next = chk_slot_reg;
        status_next   = status_reg;
        fpay_next     = fpay_reg;
        fplen_next    = fplen_reg;
        slot_next     = slot_reg;
        early         = 1'b0;
        mod_start     = 1'b0;
        mem_we        = 1'b0;
        mem_waddr     = IDX_W'(chk_slot_reg);
        mem_raddr     = IDX_W'(probe_reg);
        mem_wdata.valid = (op_reg != CMD_DELETE);
        mem_wdata.key   = key_reg[KW-1:0];
        mem_wdata.klen  = klen_reg;
        mem_wdata.pay   = pay_reg;
        mem_wdata.plen  = plen_reg;

        case (state_reg)
            S_CLEAR:
            begin
                mem_we    = 1'b1;
                mem_waddr = clr_reg;
                mem_wdata = '0;
                clr_next  = clr_reg + 1'b1;
                if (clr_reg == IDX_W'(TABLE_DEPTH - 1))
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    op_next     = cmd_t'(cmd_ch.cmd);
                    key_next    = key_m;
                    klen_next   = cmd_ch.key_length;
                    pay_next    = PW'(pay_m);
                    plen_next   = cmd_ch.payload_length;
                    status_next = ST_OK;
                    fpay_next   = '0;
                    fplen_next  = '0;
                    slot_next   = '0;
                    if (cmd_t'(cmd_ch.cmd) == CMD_INSERT)
                    begin
                        early = 1'b1;
                        if (full)
                            status_next = ST_FULL;
                        else if (key_long)
                            status_next = ST_KEY_LONG;
                        else if (pay_long)
                            status_next = ST_PAYLOAD_LONG;
                        else
                            early = 1'b0;
                    end
                    else if (cmd_t'(cmd_ch.cmd) == CMD_UPDATE && pay_long)
                    begin
                        early       = 1'b1;
                        status_next = ST_PAYLOAD_LONG;
                    end
                    if (early)
                        state_next = S_RESULT;
                    else
                    begin
                        mod_start  = 1'b1;
                        state_next = S_HASH;
                    end
                end
            end
            S_HASH:
            begin
                if (mod_done)
                begin
                    probe_next  = mod_rem;
                    issued_next = '0;
                    state_next  = S_PROBE;
                end
            end
            S_PROBE:
            begin
                if (issue)
                begin
                    chk_vld_next  = 1'b1;
                    chk_slot_next = probe_reg;
                    issued_next   = issued_reg + 1'b1;
                    probe_next    = (probe_reg == cap_eff - 1'b1) ? '0 : probe_reg + 1'b1;
                end
                if (chk_vld_reg)
                begin
                    if (op_reg == CMD_INSERT)
                    begin
                        if (!rd_data_reg.valid)
                        begin
                            mem_we     = 1'b1;
                            cnt_next   = cnt_reg + 1'b1;
                            slot_next  = SLOT_W'(chk_slot_reg);
                            state_next = S_RESULT;
                        end
                        else if (match)
                        begin
                            status_next = ST_EXISTS;
                            state_next  = S_RESULT;
                        end
                    end
                    else if (match)
                    begin
                        slot_next  = SLOT_W'(chk_slot_reg);
                        state_next = S_RESULT;
                        case (op_reg)
                            CMD_DELETE:
                            begin
                                mem_we = 1'b1;
                                if (cnt_reg != '0)
                                    cnt_next = cnt_reg - 1'b1;
                            end
                            CMD_GET:
                            begin
                                fpay_next  = WORD_W'(rd_data_reg.pay);
                                fplen_next = rd_data_reg.plen;
                            end
                            default:
                                mem_we = 1'b1;
                        endcase
                    end
                end
                else if (!issue)
                begin
                    status_next = (op_reg == CMD_INSERT) ? ST_FULL : ST_NOT_FOUND;
                    state_next  = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (res_ch.ready)
                    state_next = S_IDLE;
            end
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_CLEAR;
            cnt_reg      <= '0;
            clr_reg      <= '0;
            chk_vld_reg  <= 1'b0;
            issued_reg   <= '0;
            cap_cfg_reg  <= CAP_W'(64);
            max_klen_reg <= LEN_W'(8);
            max_plen_reg <= LEN_W'(8);
        end
        else
        begin
            state_reg   <= state_next;
            cnt_reg     <= cnt_next;
            clr_reg     <= clr_next;
            chk_vld_reg <= chk_vld_next;
            issued_reg  <= issued_next;
            if (cfg_we)
            begin
                case (cfg_idx_t'(cfg_index))
                    CFG_CAPACITY:    cap_cfg_reg  <= cfg_data;
                    CFG_MAX_KEY:     max_klen_reg <= cfg_data[LEN_W-1:0];
                    CFG_MAX_PAYLOAD: max_plen_reg <= cfg_data[LEN_W-1:0];
                    default:         cap_cfg_reg  <= cap_cfg_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg       <= op_next;
        key_reg      <= key_next;
        klen_reg     <= klen_next;
        pay_reg      <= pay_next;
        plen_reg     <= plen_next;
        probe_reg    <= probe_next;
        chk_slot_reg <= chk_slot_next;
        status_reg   <= status_next;
        fpay_reg     <= fpay_next;
        fplen_reg    <= fplen_next;
        slot_reg     <= slot_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[mem_waddr] <= mem_wdata;
        rd_data_reg <= mem[mem_raddr];
    end

    assign cmd_ch.ready                = (state_reg == S_IDLE);
    assign res_ch.valid                = (state_reg == S_RESULT);
    assign res_ch.status               = status_reg;
    assign res_ch.found_payload        = fpay_reg;
    assign res_ch.found_payload_length = fplen_reg;
    assign res_ch.slot_index           = slot_reg;
    assign res_ch.entry_count          = COUNT_W'(cnt_reg);

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(cnt_reg) <= CMP_W'(TABLE_DEPTH))
        else $error("entry count beyond table depth");

    a_probe_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE) |-> (probe_reg < cap_eff))
        else $error("probe slot outside capacity");

    a_mod_range: assert property (@(posedge clk) disable iff (!rst_n)
        mod_done |-> (mod_rem < cap_eff))
        else $error("hash remainder not below capacity");

    a_accept_next: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> (state_reg == S_HASH || state_reg == S_RESULT))
        else $error("accepted beat not taken into work");

    a_no_write_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_IDLE || state_reg == S_RESULT) |-> !mem_we)
        else $error("memory write outside clear or probe");

endmodule

// File: sim/tb.sv
// Testbench for linear_probe_hash_table_unit: random and directed table commands,
// results checked against an in-bench table model. Depends on lpht_pkg and lpht_if.
module tb;
    import lpht_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        cmd_t              cmd;
        logic [WORD_W-1:0] key_word;
        logic [LEN_W-1:0]  key_length;
        logic [WORD_W-1:0] payload_word;
        logic [LEN_W-1:0]  payload_length;
    } command_t;

    typedef struct packed {
        status_t            status;
        logic [WORD_W-1:0]  found_payload;
        logic [LEN_W-1:0]   found_payload_length;
        logic [SLOT_W-1:0]  slot_index;
        logic [COUNT_W-1:0] entry_count;
    } answer_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_we = 1'b0;
    logic [1:0] cfg_index = '0;
    logic [CFG_W-1:0] cfg_data = '0;

    lpht_cmd_if cmd_ch ();
    lpht_res_if res_ch ();

    linear_probe_hash_table_unit dut (
        .clk(clk), .rst_n(rst_n), .cmd_ch(cmd_ch), .res_ch(res_ch),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always #5 clk = ~clk;

    // table mirror
    logic              tbl_valid [64];
    logic [WORD_W-1:0] tbl_key [64];
    logic [LEN_W-1:0]  tbl_klen [64];
    logic [WORD_W-1:0] tbl_pay [64];
    logic [LEN_W-1:0]  tbl_plen [64];
    int unsigned       tbl_count;
    int unsigned       capacity_reg = 64;
    int unsigned       max_key_reg = 8;
    int unsigned       max_pay_reg = 8;

    command_t pending_cmds [$];
    answer_t  expected_answers [$];
    int       mismatches = 0;

    logic      quiet_mode = 1'b0;
    int        hold_cycles = 0;
    logic      driving = 1'b0;

    function automatic logic [WORD_W-1:0] mask_bytes(input int unsigned n);
        if (n >= 8)
            return '1;
        return (64'd1 << (8 * n)) - 64'd1;
    endfunction

    function automatic int unsigned table_cap();
        if (capacity_reg < 1)
            return 1;
        if (capacity_reg > 64)
            return 64;
        return capacity_reg;
    endfunction

    function automatic int unsigned byte_total(input logic [WORD_W-1:0] k, input int unsigned n);
        int unsigned s;
        s = 0;
        for (int i = 0; i < n && i < 8; i++)
            s += k[8*i +: 8];
        return s;
    endfunction

    function automatic int find_slot(input logic [WORD_W-1:0] k, input int unsigned n,
                                     input int unsigned cap);
        int unsigned base;
        int unsigned s;
        base = byte_total(k, n);
        for (int p = 0; p < cap; p++)
        begin
            s = (base + p) % cap;
            if (tbl_valid[s] && tbl_klen[s] == n && tbl_key[s] == k)
                return s;
        end
        return -1;
    endfunction

    function automatic answer_t apply_command(input command_t c);
        answer_t a;
        int unsigned klen, plen, cap, base, s;
        logic [WORD_W-1:0] k, pay;
        logic key_long, pay_long, done;
        int f;
        klen = c.key_length;
        plen = c.payload_length;
        k = c.key_word & mask_bytes(klen);
        pay = c.payload_word & mask_bytes(plen);
        cap = table_cap();
        key_long = klen > max_key_reg || klen > 8;
        pay_long = plen > max_pay_reg || plen > 8;
        a = '0;
        a.status = ST_OK;
        case (c.cmd)
            CMD_INSERT:
            begin
                if (tbl_count >= cap)
                    a.status = ST_FULL;
                else if (key_long)
                    a.status = ST_KEY_LONG;
                else if (pay_long)
                    a.status = ST_PAYLOAD_LONG;
                else
                begin
                    base = byte_total(k, klen);
                    done = 1'b0;
                    for (int p = 0; p < cap && !done; p++)
                    begin
                        s = (base + p) % cap;
                        if (!tbl_valid[s])
                        begin
                            tbl_valid[s] = 1'b1;
                            tbl_key[s] = k;
                            tbl_klen[s] = LEN_W'(klen);
                            tbl_pay[s] = pay;
                            tbl_plen[s] = LEN_W'(plen);
                            tbl_count++;
                            a.slot_index = SLOT_W'(s);
                            done = 1'b1;
                        end
                        else if (tbl_klen[s] == klen && tbl_key[s] == k)
                        begin
                            a.status = ST_EXISTS;
                            done = 1'b1;
                        end
                    end
                    if (!done)
                        a.status = ST_FULL;
                end
            end
            CMD_DELETE:
            begin
                f = find_slot(k, klen, cap);
                if (f < 0)
                    a.status = ST_NOT_FOUND;
                else
                begin
                    a.slot_index = SLOT_W'(f);
                    tbl_valid[f] = 1'b0;
                    if (tbl_count > 0)
                        tbl_count--;
                end
            end
            CMD_GET:
            begin
                f = find_slot(k, klen, cap);
                if (f < 0)
                    a.status = ST_NOT_FOUND;
                else
                begin
                    a.slot_index = SLOT_W'(f);
                    a.found_payload = tbl_pay[f];
                    a.found_payload_length = tbl_plen[f];
                end
            end
            default:
            begin
                if (pay_long)
                    a.status = ST_PAYLOAD_LONG;
                else
                begin
                    f = find_slot(k, klen, cap);
                    if (f < 0)
                        a.status = ST_NOT_FOUND;
                    else
                    begin
                        a.slot_index = SLOT_W'(f);
                        tbl_pay[f] = pay;
                        tbl_plen[f] = LEN_W'(plen);
                    end
                end
            end
        endcase
        if (a.status != ST_OK)
            a.slot_index = '0;
        a.entry_count = COUNT_W'(tbl_count);
        return a;
    endfunction

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_ch.cmd <= CMD_INSERT;
            cmd_ch.key_word <= '0;
            cmd_ch.key_length <= '0;
            cmd_ch.payload_word <= '0;
            cmd_ch.payload_length <= '0;
        end
        else
        begin
            if (cmd_ch.valid && cmd_ch.ready)
                expected_answers.push_back(apply_command(pending_cmds.pop_front()));
            if (!(cmd_ch.valid && !cmd_ch.ready))
            begin
                if (driving && pending_cmds.size() > 0 &&
                    (quiet_mode || $urandom_range(99) >= 28))
                begin
                    {cmd_ch.cmd, cmd_ch.key_word, cmd_ch.key_length,
                     cmd_ch.payload_word, cmd_ch.payload_length} <= pending_cmds[0];
                    cmd_ch.valid <= 1'b1;
                end
                else
                    cmd_ch.valid <= 1'b0;
            end
        end
    end

    // receiver stall counter
    always @(posedge clk)
    begin
        if (hold_cycles > 0)
            hold_cycles <= hold_cycles - 1;
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        answer_t got, want;
        if (!rst_n)
            res_ch.ready <= 1'b0;
        else
        begin
            if (res_ch.valid && res_ch.ready)
            begin
                got.status = status_t'(res_ch.status);
                got.found_payload = res_ch.found_payload;
                got.found_payload_length = res_ch.found_payload_length;
                got.slot_index = res_ch.slot_index;
                got.entry_count = res_ch.entry_count;
                if (expected_answers.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result beat %p", got);
                end
                else
                begin
                    want = expected_answers.pop_front();
                    if (got.status !== want.status ||
                        got.found_payload !== want.found_payload ||
                        got.found_payload_length !== want.found_payload_length ||
                        got.slot_index !== want.slot_index ||
                        got.entry_count !== want.entry_count)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("mismatch: expected %p actual %p", want, got);
                    end
                end
            end
            res_ch.ready <= (hold_cycles == 0) &&
                            (quiet_mode || $urandom_range(99) >= 28);
        end
    end

    task automatic write_reg(input cfg_idx_t idx, input int unsigned val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= CFG_W'(val);
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_CAPACITY:    capacity_reg = val & 7'h7F;
            CFG_MAX_KEY:     max_key_reg = val & 4'hF;
            default:         max_pay_reg = val & 4'hF;
        endcase
    endtask

    task automatic drain();
        driving = 1'b1;
        while (pending_cmds.size() > 0 || expected_answers.size() > 0)
            @(posedge clk);
        driving = 1'b0;
        repeat (100) @(posedge clk);
    endtask

    function automatic command_t make_cmd(input cmd_t op, input logic [WORD_W-1:0] k,
                                          input int unsigned kl, input logic [WORD_W-1:0] pw,
                                          input int unsigned pl);
        command_t c;
        c.cmd = op;
        c.key_word = k;
        c.key_length = LEN_W'(kl);
        c.payload_word = pw;
        c.payload_length = LEN_W'(pl);
        return c;
    endfunction

    function automatic logic [WORD_W-1:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    // keys from a small pool so lookups hit
    logic [WORD_W-1:0] key_pool [16];
    int unsigned       klen_pool [16];

    function automatic command_t rand_cmd();
        int unsigned r;
        int unsigned kl, pl;
        r = $urandom_range(15);
        pl = $urandom_range(99) < 5 ? $urandom_range(15) : $urandom_range(8);
        if ($urandom_range(99) < 85)
            return make_cmd(cmd_t'($urandom_range(3)), key_pool[r], klen_pool[r],
                            rand_word(), pl);
        kl = $urandom_range(15);
        return make_cmd(cmd_t'($urandom_range(3)), rand_word(), kl, rand_word(), pl);
    endfunction

    initial
    begin
        for (int i = 0; i < 64; i++)
            tbl_valid[i] = 1'b0;
        tbl_count = 0;
        for (int i = 0; i < 16; i++)
        begin
            key_pool[i] = rand_word();
            klen_pool[i] = $urandom_range(1, 8);
        end
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed
        pending_cmds.push_back(make_cmd(CMD_GET, 64'h0, 1, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, '1, 8, '1, 8));
        pending_cmds.push_back(make_cmd(CMD_INSERT, '1, 8, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_GET, '1, 8, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'hAA, 0, 64'h55, 3));
        pending_cmds.push_back(make_cmd(CMD_GET, 64'h0, 0, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h1, 9, 64'h0, 1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h2, 1, 64'h0, 15));
        pending_cmds.push_back(make_cmd(CMD_UPDATE, '1, 8, 64'h1234, 2));
        pending_cmds.push_back(make_cmd(CMD_UPDATE, '1, 8, 64'h0, 9));
        pending_cmds.push_back(make_cmd(CMD_UPDATE, 64'h77, 1, 64'h0, 1));
        pending_cmds.push_back(make_cmd(CMD_GET, '1, 8, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h0100, 2, 64'h1, 1));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h0001, 2, 64'h2, 1));
        pending_cmds.push_back(make_cmd(CMD_DELETE, 64'h0100, 2, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_GET, 64'h0001, 2, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_DELETE, 64'h0100, 2, 64'h0, 0));
        drain();

        // small table, tight limits: fill it, then shrink below the fill
        write_reg(CFG_CAPACITY, 2);
        write_reg(CFG_MAX_KEY, 1);
        write_reg(CFG_MAX_PAYLOAD, 0);
        for (int i = 0; i < 6; i++)
            pending_cmds.push_back(make_cmd(CMD_INSERT, i, 1, 64'hFF, i % 2));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h5, 2, 64'h0, 0));
        drain();
        write_reg(CFG_CAPACITY, 0);
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h9, 1, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_DELETE, 64'h1, 1, 64'h0, 0));
        pending_cmds.push_back(make_cmd(CMD_INSERT, 64'h9, 1, 64'h0, 0));
        drain();
        write_reg(CFG_CAPACITY, 127);
        write_reg(CFG_MAX_KEY, 15);
        write_reg(CFG_MAX_PAYLOAD, 15);

        // random phases; the first runs without idling, the second opens with a long stall
        for (int ph = 0; ph < 5; ph++)
        begin
            quiet_mode = (ph == 0);
            if (ph == 1)
                hold_cycles = 2000;
            for (int i = 0; i < 100; i++)
                pending_cmds.push_back(rand_cmd());
            drain();
            write_reg(CFG_CAPACITY, ph == 2 ? 5 : $urandom_range(1, 64));
            write_reg(CFG_MAX_KEY, $urandom_range(1, 8));
            write_reg(CFG_MAX_PAYLOAD, $urandom_range(0, 8));
        end
        quiet_mode = 1'b0;
        repeat (100) @(posedge clk);

        if (mismatches == 0 && expected_answers.size() == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end

    initial
    begin
        #5ms;
        $display("tb failed");
        $finish;
    end
endmodule

// File: filelist.f
src/lpht_pkg.sv
src/lpht_if.sv
src/lpht_mod.sv
src/linear_probe_hash_table_unit.sv
sim/tb.sv
